>>> rtl/core/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and calendar helpers for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;

    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd1900;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

    // 25 * INV25 == 1 mod 2**14, so y is a multiple of 25 exactly when
    // y * INV25 (mod 2**14) lands at or below floor((2**14 - 1) / 25)
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_BACK = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WORK = 1'b1
    } state_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        // multiple of 4, and either not of 100 or also of 400
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/cds_day_unit.sv
// ----------------------------------------------------------------------------
// cds_day_unit
// Moves a date by one day forward or backward and gives the month length.
// ----------------------------------------------------------------------------
module cds_day_unit (
    input  cds_pkg::date_t                 cur,
    input  logic                           backward,
    output cds_pkg::date_t                 nxt,
    output logic [cds_pkg::DAY_W-1:0]      mlen
);
    import cds_pkg::*;

    logic               leap;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] prev_month;

    assign leap       = is_leap(cur.year);
    assign mlen       = month_days(cur.month, leap);
    assign prev_month = cur.month - 4'd1;
    assign prev_len   = month_days(prev_month, leap);

    always_comb
    begin
        nxt = cur;
        if (!backward)
        begin
            if (cur.day >= mlen)
            begin
                nxt.day = 5'd1;
                if (cur.month >= MONTHS_PER_YEAR)
                begin
                    nxt.month = 4'd1;
                    nxt.year  = cur.year + 14'd1;
                end
                else
                begin
                    nxt.month = cur.month + 4'd1;
                end
            end
            else
            begin
                nxt.day = cur.day + 5'd1;
            end
        end
        else
        begin
            if (cur.day <= 5'd1)
            begin
                if (cur.month <= 4'd1)
                begin
                    // into december of the year before
                    nxt.month = MONTHS_PER_YEAR;
                    nxt.year  = cur.year - 14'd1;
                    nxt.day   = month_days(MONTHS_PER_YEAR, 1'b0);
                end
                else
                begin
                    nxt.month = prev_month;
                    nxt.day   = prev_len;
                end
            end
            else
            begin
                nxt.day = cur.day - 5'd1;
            end
        end
    end

endmodule

>>> rtl/core/calendar_date_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date register with validated set and saturating day stepping.
// ----------------------------------------------------------------------------
// An item is taken while the block is idle and worked in the work state. A set
// item is checked there and its result loaded into the output register. A step
// item of n days moves the date one day per cycle through a single day-step
// unit, its last day waiting while the output is stalled; the step ends early
// when it saturates at 1 january of MIN_YEAR or 31 december of MAX_YEAR. The
// input is stalled while an item is being worked; it is open again as soon as
// the result is in the output register, and a result held by a stalled output
// delays only the finish of the following item.
module calendar_date_stepper #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 9999
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [cds_pkg::DAY_W-1:0]     new_day,
    input  logic [cds_pkg::MONTH_W-1:0]   new_month,
    input  logic [cds_pkg::YEAR_W-1:0]    new_year,
    input  logic [cds_pkg::COUNT_W-1:0]   step_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cds_pkg::DAY_W-1:0]     day_out,
    output logic [cds_pkg::MONTH_W-1:0]   month_out,
    output logic [cds_pkg::YEAR_W-1:0]    year_out,
    output logic                          ok
);
    import cds_pkg::*;

    localparam logic [YEAR_W-1:0] MIN_Y = YEAR_W'(MIN_YEAR);
    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    state_t             state_reg, state_next;
    date_t              cur_reg, cur_next;
    date_t              set_reg;
    logic [1:0]         kind_reg;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    date_t              out_date_reg;
    logic               ok_reg;

    date_t              unit_in, unit_out;
    logic [DAY_W-1:0]   unit_mlen;
    logic               at_floor, at_ceiling, at_limit;
    logic               set_good;
    logic               can_finish;
    logic               finish;
    logic               fin_ok;
    logic               out_load;
    logic               accept;

    assign accept     = in_valid && !in_stall;
    assign can_finish = !out_valid_reg || !out_stall;

    // the shared unit sees the requested date for a set, the held date otherwise
    assign unit_in = (kind_reg == KIND_SET) ? set_reg : cur_reg;

    cds_day_unit u_day (
        .cur      (unit_in),
        .backward (kind_reg == KIND_BACK),
        .nxt      (unit_out),
        .mlen     (unit_mlen)
    );

    assign at_floor   = (cur_reg.year < MIN_Y) ||
                        ((cur_reg.year == MIN_Y) && (cur_reg.month <= 4'd1) &&
                         (cur_reg.day <= 5'd1));
    assign at_ceiling = (cur_reg.year > MAX_Y) ||
                        ((cur_reg.year == MAX_Y) && (cur_reg.month >= MONTHS_PER_YEAR) &&
                         (cur_reg.day >= 5'd31));
    assign at_limit   = (kind_reg == KIND_BACK) ? at_floor : at_ceiling;

    assign set_good = (set_reg.month >= 4'd1) && (set_reg.month <= MONTHS_PER_YEAR) &&
                      (set_reg.year >= MIN_Y) && (set_reg.year <= MAX_Y) &&
                      (set_reg.day >= 5'd1) && (set_reg.day <= unit_mlen);

    // work decision for the current cycle
    always_comb
    begin
        finish   = 1'b0;
        fin_ok   = 1'b0;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        if (state_reg == ST_WORK)
        begin
            case (kind_reg)
                KIND_SET:
                begin
                    finish = 1'b1;
                    fin_ok = set_good;
                    if (set_good && can_finish)
                        cur_next = set_reg;
                end
                KIND_FWD, KIND_BACK:
                begin
                    if (cnt_reg == '0)
                    begin
                        finish = 1'b1;
                        fin_ok = 1'b1;
                    end
                    else if (at_limit)
                    begin
                        finish = 1'b1;
                        fin_ok = 1'b0;
                    end
                    else if (cnt_reg == COUNT_W'(1))
                    begin
                        // last day: result shows the moved date
                        finish = 1'b1;
                        fin_ok = 1'b1;
                        if (can_finish)
                        begin
                            cur_next = unit_out;
                            cnt_next = '0;
                        end
                    end
                    else
                    begin
                        cur_next = unit_out;
                        cnt_next = cnt_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    finish = 1'b1;
                    fin_ok = 1'b0;
                end
            endcase
        end
    end

    assign out_load = finish && can_finish;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_WORK;
            ST_WORK: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_WORK: if (out_load) out_valid_next = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg.day   <= RESET_DAY;
            cur_reg.month <= RESET_MONTH;
            cur_reg.year  <= RESET_YEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= kind;
            set_reg.day   <= new_day;
            set_reg.month <= new_month;
            set_reg.year  <= new_year;
            cnt_reg       <= step_count;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
        if (out_load)
        begin
            out_date_reg <= cur_next;
            ok_reg       <= fin_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign day_out   = out_date_reg.day;
    assign month_out = out_date_reg.month;
    assign year_out  = out_date_reg.year;
    assign ok        = ok_reg;

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_WORK)
        else $error("accepted item did not start work");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg.day >= 5'd1) && (cur_reg.month >= 4'd1) &&
        (cur_reg.month <= MONTHS_PER_YEAR))
        else $error("held date out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while held");

endmodule
